[rtl/core/mwsf_pkg.sv]
// Shared types, constants and helpers of the minimum window substring finder.
`default_nettype none
package mwsf_pkg;

	// Number of character slots and width of a text position.
	localparam int MAX_SLOTS = 8;
	localparam int POS_BITS = 16;

	// Derived widths.
	localparam int CNT_W = POS_BITS + 1;
	localparam int SLOT_CNT_W = $clog2(MAX_SLOTS + 1);
	localparam int CHAR_W = 8;
	localparam int MATCH_W = 64;
	localparam int COUNT_REG_W = 4;
	localparam int FIELD_W = 16;
	localparam int STATUS_W = 2;
	localparam int CFG_IDX_W = 1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_MATCH_CHARS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHAR_COUNT = 1'd1;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_FOUND = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NONE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_SET_BIG = 2'd2;
	localparam logic [STATUS_W-1:0] ST_TOO_LONG = 2'd3;

	// One byte travelling down the row of slot cells.
	typedef struct packed {
		logic                valid;
		logic                upd;
		logic [CHAR_W-1:0]   ch;
		logic [POS_BITS-1:0] pos;
		logic                last;
		logic [POS_BITS-1:0] oldest;
		logic                complete;
		logic                set_big;
		logic                too_long;
	} token_t;

	// Clamp a value to the range of a 16-bit result field.
	function automatic logic [FIELD_W-1:0] sat_field(input logic [32:0] v);
		logic [FIELD_W-1:0] r;
		if (v > 33'd65535) begin
			r = '1;
		end else begin
			r = v[FIELD_W-1:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

[rtl/core/mwsf_head.sv]
// Input stage: text position counter and the token that enters the cell row.
`default_nettype none
module mwsf_head (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              enable,
	input  wire logic                              item_valid,
	input  wire logic [mwsf_pkg::CHAR_W-1:0]       ch,
	input  wire logic                              last,
	input  wire logic [mwsf_pkg::SLOT_CNT_W-1:0]   n_active,
	output mwsf_pkg::token_t                       tok
);
	import mwsf_pkg::*;

	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_after;
	logic             in_range;

	// Position counter saturates one past the last valid position.
	assign in_range = !cnt_q[POS_BITS];
	assign cnt_after = in_range ? cnt_q + CNT_W'(1) : cnt_q;

	// Build the token; the text length checks are settled here.
	always_comb begin
		tok.valid = item_valid;
		tok.upd = item_valid && in_range;
		tok.ch = ch;
		tok.pos = cnt_q[POS_BITS-1:0];
		tok.last = last;
		tok.oldest = cnt_q[POS_BITS-1:0];
		tok.complete = 1'b1;
		tok.set_big = CNT_W'(n_active) > cnt_after;
		tok.too_long = cnt_after[POS_BITS];
	end

	// Count accepted bytes and restart after the final one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (enable && item_valid) begin
			cnt_q <= last ? '0 : cnt_after;
		end
	end

endmodule
`default_nettype wire

[rtl/core/mwsf_cell.sv]
// One slot cell: last seen position of its character and its part of the minimum.
`default_nettype none
module mwsf_cell (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        enable,
	input  wire logic [mwsf_pkg::CHAR_W-1:0] slot_char,
	input  wire logic                        active,
	input  wire mwsf_pkg::token_t            tok_in,
	output mwsf_pkg::token_t                 tok_out
);
	import mwsf_pkg::*;

	logic                seen_q;
	logic [POS_BITS-1:0] last_pos_q;
	logic                hit;
	logic                cur_seen;
	logic [POS_BITS-1:0] cur_pos;
	token_t              nxt;
	token_t              tok_s1;

	// Slot state as it stands after this byte.
	assign hit = tok_in.upd && (tok_in.ch == slot_char);
	assign cur_seen = seen_q || hit;
	assign cur_pos = hit ? tok_in.pos : last_pos_q;

	// Fold this slot into the running completeness flag and oldest position.
	always_comb begin
		nxt = tok_in;
		nxt.complete = tok_in.complete && (!active || cur_seen);
		if (active && cur_seen && (cur_pos < tok_in.oldest)) begin
			nxt.oldest = cur_pos;
		end
	end

	// Seen bit; cleared once the final byte of a text has passed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
		end else if (enable && tok_in.valid) begin
			seen_q <= tok_in.last ? 1'b0 : cur_seen;
		end
	end

	// Last position is read only while the seen bit is set.
	always_ff @(posedge clk) begin
		if (enable && hit) begin
			last_pos_q <= tok_in.pos;
		end
	end

	// Hand the token to the next cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
		end else if (enable) begin
			tok_s1 <= nxt;
		end
	end

	assign tok_out = tok_s1;

endmodule
`default_nettype wire

[rtl/core/mwsf_tail.sv]
// Final stage: best window tracking and the result register.
`default_nettype none
module mwsf_tail (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          enable,
	input  wire mwsf_pkg::token_t              tok,
	output logic                               res_valid,
	output logic [mwsf_pkg::STATUS_W-1:0]      status,
	output logic [mwsf_pkg::FIELD_W-1:0]       start_res,
	output logic [mwsf_pkg::FIELD_W-1:0]       length
);
	import mwsf_pkg::*;

	logic                found_q;
	logic [POS_BITS-1:0] best_start_q;
	logic [CNT_W-1:0]    best_len_q;
	logic [CNT_W-1:0]    len;
	logic                take;
	logic                nb_found;
	logic [POS_BITS-1:0] nb_start;
	logic [CNT_W-1:0]    nb_len;
	logic                res_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [FIELD_W-1:0]  start_q;
	logic [FIELD_W-1:0]  length_q;
	logic [STATUS_W-1:0] r_status;
	logic [FIELD_W-1:0]  r_start;
	logic [FIELD_W-1:0]  r_len;

	// Window ending at this byte and whether it beats the best one.
	assign len = {1'b0, tok.pos} - {1'b0, tok.oldest} + CNT_W'(1);
	assign take = tok.upd && tok.complete && (!found_q || (len < best_len_q));
	assign nb_found = take || found_q;
	assign nb_start = take ? tok.oldest : best_start_q;
	assign nb_len = take ? len : best_len_q;

	// Result for the final byte; length checks take priority.
	always_comb begin
		r_start = '0;
		r_len = '0;
		if (tok.set_big) begin
			r_status = ST_SET_BIG;
		end else if (tok.too_long) begin
			r_status = ST_TOO_LONG;
		end else if (nb_found) begin
			r_status = ST_FOUND;
			r_start = sat_field(33'(nb_start));
			r_len = sat_field(33'(nb_len));
		end else begin
			r_status = ST_NONE;
		end
	end

	// Best window state, cleared at the end of each text.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			best_start_q <= '0;
			best_len_q <= '0;
		end else if (enable && tok.valid) begin
			if (tok.last) begin
				found_q <= 1'b0;
				best_start_q <= '0;
				best_len_q <= '0;
			end else begin
				found_q <= nb_found;
				best_start_q <= nb_start;
				best_len_q <= nb_len;
			end
		end
	end

	// Result valid flag; the row only moves when the register is free or taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (enable) begin
			res_valid_q <= tok.valid && tok.last;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (enable && tok.valid && tok.last) begin
			status_q <= r_status;
			start_q <= r_start;
			length_q <= r_len;
		end
	end

	assign res_valid = res_valid_q;
	assign status = status_q;
	assign start_res = start_q;
	assign length = length_q;

endmodule
`default_nettype wire

[rtl/core/min_window_substring_finder_unit.sv]
// Top level of the minimum window substring finder: config registers and the cell row.
//
//  channel  direction  handshake                 payload
//  item     in         item_valid / item_stall   ch, last
//  result   out        res_valid / res_stall     status, start_res, length
//  config   in         cfg_we                    cfg_index, cfg_data
//
// One byte is taken every cycle while item_stall is low. A byte crosses one slot
// cell per cycle while the row moves; its result is registered in the tail after the last cell.
// Reset clears the seen bits, counters and best window at once; no clearing pass.
// While a result is held and res_stall is high the whole row freezes and
// item_stall is raised; otherwise the row moves every cycle.
`default_nettype none
module min_window_substring_finder_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              item_valid,
	output logic                                   item_stall,
	input  wire logic [mwsf_pkg::CHAR_W-1:0]       ch,
	input  wire logic                              last,
	output logic                                   res_valid,
	input  wire logic                              res_stall,
	output logic [mwsf_pkg::STATUS_W-1:0]          status,
	output logic [mwsf_pkg::FIELD_W-1:0]           start_res,
	output logic [mwsf_pkg::FIELD_W-1:0]           length,
	input  wire logic                              cfg_we,
	input  wire logic [mwsf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [mwsf_pkg::MATCH_W-1:0]      cfg_data
);
	import mwsf_pkg::*;

	logic [MATCH_W-1:0]     match_chars_q;
	logic [COUNT_REG_W-1:0] char_count_q;
	logic [SLOT_CNT_W-1:0]  n_active;
	logic                   enable;
	token_t                 tok [MAX_SLOTS+1];

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_chars_q <= '0;
			char_count_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MATCH_CHARS: match_chars_q <= cfg_data;
				REG_CHAR_COUNT:  char_count_q <= cfg_data[COUNT_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// Counts above the number of slots act as all slots.
	assign n_active = (char_count_q > COUNT_REG_W'(MAX_SLOTS)) ?
		SLOT_CNT_W'(MAX_SLOTS) : SLOT_CNT_W'(char_count_q);

	// The row advances unless a held result is being stalled.
	assign enable = !(res_valid && res_stall);
	assign item_stall = !enable;

	mwsf_head u_head (
		.clk        (clk),
		.arst_n     (arst_n),
		.enable     (enable),
		.item_valid (item_valid),
		.ch         (ch),
		.last       (last),
		.n_active   (n_active),
		.tok        (tok[0])
	);

	// Row of slot cells, one per character slot; only the first n_active slots are active.
	for (genvar k = 0; k < MAX_SLOTS; k++) begin : g_cell
		mwsf_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.enable    (enable),
			.slot_char (match_chars_q[CHAR_W*k +: CHAR_W]),
			.active    (SLOT_CNT_W'(k) < n_active),
			.tok_in    (tok[k]),
			.tok_out   (tok[k+1])
		);
	end

	mwsf_tail u_tail (
		.clk       (clk),
		.arst_n    (arst_n),
		.enable    (enable),
		.tok       (tok[MAX_SLOTS]),
		.res_valid (res_valid),
		.status    (status),
		.start_res (start_res),
		.length    (length)
	);

endmodule
`default_nettype wire

[rtl/core/mwsf_checker.sv]
// Port-level checks of the minimum window substring finder and their binding.
`default_nettype none
module mwsf_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              item_valid,
	input wire logic                              item_stall,
	input wire logic                              res_valid,
	input wire logic                              res_stall,
	input wire logic [mwsf_pkg::STATUS_W-1:0]     status,
	input wire logic [mwsf_pkg::FIELD_W-1:0]      start_res,
	input wire logic [mwsf_pkg::FIELD_W-1:0]      length
);
	import mwsf_pkg::*;

	// A stalled result holds its value.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(status) &&
			$stable(start_res) && $stable(length))
		else $error("result changed while stalled");

	// Input is held off only while a result is stuck at the output.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> !item_stall)
		else $error("input stalled with no result waiting");

	// A found window is never empty.
	a_found_len: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (status == ST_FOUND) |-> (length != '0))
		else $error("found window with zero length");

	// Any other status reports a zero start and length.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (status != ST_FOUND) |-> (start_res == '0) && (length == '0))
		else $error("nonzero fields without a window");

endmodule

bind min_window_substring_finder_unit mwsf_checker u_mwsf_checker (.*);
`default_nettype wire
